### hw/rtl/jbr_pkg.sv
// ----------------------------------------------------------------------------
// jbr_pkg
// Shared types, codes and helpers for the entropy bit reader with unstuffing.
// ----------------------------------------------------------------------------
package jbr_pkg;

	localparam int FIFO_DEPTH    = 8;
	localparam int MAX_READ_BITS = 16;

	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_FILL_W = $clog2(FIFO_DEPTH + 1);

	// opcodes
	localparam logic [2:0] OP_PUSH   = 3'd0;
	localparam logic [2:0] OP_READ_U = 3'd1;
	localparam logic [2:0] OP_READ_S = 3'd2;
	localparam logic [2:0] OP_READ_B = 3'd3;
	localparam logic [2:0] OP_READ_W = 3'd4;
	localparam logic [2:0] OP_ALIGN  = 3'd5;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_MARKER    = 3'd2;
	localparam logic [2:0] ST_UNALIGNED = 3'd3;
	localparam logic [2:0] ST_TOO_MANY  = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] stream_byte;
		logic [4:0] bit_count;
	} req_t;

	typedef struct packed {
		logic [15:0] value;
		logic [2:0]  status;
	} rsp_t;

	typedef struct packed {
		logic                   push;
		logic                   commit;
		logic [FIFO_PTR_W-1:0]  head;
		logic [FIFO_FILL_W-1:0] fill;
	} jbr_fifo_ctl_t;

	typedef struct packed {
		logic       restore;
		logic       load;
		logic [7:0] load_byte;
		logic       shift;
		logic       commit;
		logic       marker;
		logic       align;
	} jbr_shift_cmd_t;

	function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
		logic [FIFO_PTR_W-1:0] r;
		if (p == FIFO_PTR_W'(FIFO_DEPTH - 1))
			r = '0;
		else
			r = p + FIFO_PTR_W'(1);
		return r;
	endfunction

endpackage

### hw/rtl/jbr_fifo.sv
// ----------------------------------------------------------------------------
// jbr_fifo
// Raw stream byte store: circular buffer with committed head and fill,
// registered read port addressed by the sequencer's working head.
// ----------------------------------------------------------------------------
module jbr_fifo import jbr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  jbr_fifo_ctl_t          ctl,
	input  logic [7:0]             wr_data,
	input  logic [FIFO_PTR_W-1:0]  rd_addr,
	output logic [7:0]             rd_data,
	output logic [FIFO_PTR_W-1:0]  head,
	output logic [FIFO_FILL_W-1:0] fill
);

	logic [7:0]             mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  head_q;
	logic [FIFO_FILL_W-1:0] fill_q;
	logic [FIFO_PTR_W:0]    wr_sum;
	logic [FIFO_PTR_W-1:0]  wr_addr;

	// head + fill stays below twice the depth, one subtract wraps it
	always_comb begin
		wr_sum = {1'b0, head_q} + (FIFO_PTR_W + 1)'(fill_q);
		if (wr_sum >= (FIFO_PTR_W + 1)'(FIFO_DEPTH))
			wr_sum = wr_sum - (FIFO_PTR_W + 1)'(FIFO_DEPTH);
		wr_addr = wr_sum[FIFO_PTR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.push)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (ctl.commit) begin
			head_q <= ctl.head;
			fill_q <= ctl.fill;
		end else if (ctl.push) begin
			fill_q <= fill_q + FIFO_FILL_W'(1);
		end
	end

	assign head = head_q;
	assign fill = fill_q;

endmodule

### hw/rtl/jbr_shift.sv
// ----------------------------------------------------------------------------
// jbr_shift
// Bit shift unit: committed and working copies of the current byte, and the
// accumulator that takes one bit per step, MSB first.
// ----------------------------------------------------------------------------
module jbr_shift import jbr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  jbr_shift_cmd_t cmd,
	output logic [15:0]    acc,
	output logic [3:0]     left_w,
	output logic [3:0]     left
);

	logic [7:0]  cur_q;
	logic [3:0]  left_q;
	logic [7:0]  cur_w_q;
	logic [3:0]  left_w_q;
	logic [15:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			left_q   <= '0;
			cur_w_q  <= '0;
			left_w_q <= '0;
			acc_q    <= '0;
		end else begin
			if (cmd.align) begin
				cur_q  <= '0;
				left_q <= '0;
			end else if (cmd.marker) begin
				cur_q  <= 8'hFF;
				left_q <= 4'd8;
			end else if (cmd.commit) begin
				cur_q  <= cur_w_q;
				left_q <= left_w_q;
			end

			if (cmd.restore) begin
				cur_w_q  <= cur_q;
				left_w_q <= left_q;
				acc_q    <= '0;
			end else if (cmd.load) begin
				cur_w_q  <= cmd.load_byte;
				left_w_q <= 4'd8;
			end else if (cmd.shift) begin
				acc_q    <= {acc_q[14:0], cur_w_q[7]};
				cur_w_q  <= {cur_w_q[6:0], 1'b0};
				left_w_q <= left_w_q - 4'd1;
			end
		end
	end

	assign acc    = acc_q;
	assign left_w = left_w_q;
	assign left   = left_q;

endmodule

### hw/rtl/jpeg_bit_reader_unstuff.sv
// ----------------------------------------------------------------------------
// jpeg_bit_reader_unstuff
// Entropy-coded segment bit reader with 0xFF 0x00 unstuffing.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready), one opcode per beat: push a raw byte,
// read 0..16 bits unsigned or jpeg-extended, read a raw byte or word, align.
// Every request gives exactly one beat on rsp with value and status.
// A bit read steps the shared shift unit one bit per cycle while the current
// byte has bits left; a byte loaded from the store passes through S_FETCH,
// a stuffed 0xFF 0x00 pair also through S_FF_WAIT and S_FF_CHK. Raw reads go
// through S_RAW_WAIT and S_RAW_HI, a word also through S_RAW_WAIT_LO and
// S_RAW_LO; every request ends in S_DONE. One request is in work at a time;
// req_ready is high only while the sequencer is idle.
// The finished result sits in an output register, so the next request is
// taken while rsp waits; a stalled rsp holds the sequencer only once it has
// a second result ready. Reset clears the store pointers, the bit buffer
// and rsp_valid; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
module jpeg_bit_reader_unstuff import jbr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_BIT,
		S_FETCH,
		S_FF_WAIT,
		S_FF_CHK,
		S_RAW_WAIT,
		S_RAW_HI,
		S_RAW_WAIT_LO,
		S_RAW_LO,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [2:0]             op_q;
	logic [4:0]             n_q;
	logic [4:0]             cnt_q;
	logic                   word_q;
	logic [FIFO_PTR_W-1:0]  head_w_q;
	logic [FIFO_FILL_W-1:0] fill_w_q;
	logic [15:0]            res_value_q;
	logic [2:0]             res_status_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	jbr_fifo_ctl_t          fifo_ctl;
	jbr_shift_cmd_t         sh_cmd;
	logic [7:0]             rd_data;
	logic [FIFO_PTR_W-1:0]  fifo_head;
	logic [FIFO_FILL_W-1:0] fifo_fill;
	logic [15:0]            acc;
	logic [3:0]             left_w;
	logic [3:0]             left;

	logic                   accept;
	logic                   rsp_load;
	logic [FIFO_PTR_W-1:0]  head_inc;
	logic [FIFO_FILL_W-1:0] fill_dec;
	logic [15:0]            ext_mask;
	logic [15:0]            bits_value;
	logic [2:0]             start_status;
	state_t                 start_state;

	assign accept   = req_valid && req_ready;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	assign head_inc = ptr_inc(head_w_q);
	assign fill_dec = fill_w_q - FIFO_FILL_W'(1);

	// jpeg extend: a leading zero bit means a negative value
	always_comb begin
		ext_mask = ~(16'hFFFF << n_q);
		bits_value = acc;
		if (op_q == OP_READ_S && !acc[4'(n_q - 5'd1)])
			bits_value = acc - ext_mask;
	end

	// first status and state for a newly taken request
	always_comb begin
		start_status = ST_OK;
		start_state  = S_DONE;
		case (req.opcode)
			OP_PUSH: begin
				if (fifo_fill == FIFO_FILL_W'(FIFO_DEPTH))
					start_status = ST_FULL;
			end
			OP_READ_U, OP_READ_S: begin
				if (req.bit_count > 5'(MAX_READ_BITS))
					start_status = ST_TOO_MANY;
				else if (req.bit_count != 5'd0)
					start_state = S_BIT;
			end
			OP_READ_B: begin
				if (left != 4'd0)
					start_status = ST_UNALIGNED;
				else if (fifo_fill == FIFO_FILL_W'(0))
					start_status = ST_UNDERFLOW;
				else
					start_state = S_RAW_WAIT;
			end
			OP_READ_W: begin
				if (left != 4'd0)
					start_status = ST_UNALIGNED;
				else if (fifo_fill < FIFO_FILL_W'(2))
					start_status = ST_UNDERFLOW;
				else
					start_state = S_RAW_WAIT;
			end
			default: ;
		endcase
	end

	jbr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fifo_ctl),
		.wr_data (req.stream_byte),
		.rd_addr (head_w_q),
		.rd_data (rd_data),
		.head    (fifo_head),
		.fill    (fifo_fill)
	);

	jbr_shift u_shift (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (sh_cmd),
		.acc    (acc),
		.left_w (left_w),
		.left   (left)
	);

	always_comb begin
		sh_cmd        = '0;
		fifo_ctl      = '0;
		fifo_ctl.head = head_inc;
		fifo_ctl.fill = fill_dec;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.opcode)
						OP_PUSH: begin
							fifo_ctl.push = (fifo_fill != FIFO_FILL_W'(FIFO_DEPTH));
						end
						OP_READ_U, OP_READ_S: begin
							sh_cmd.restore = (req.bit_count <= 5'(MAX_READ_BITS))
								&& (req.bit_count != 5'd0);
						end
						OP_ALIGN: begin
							sh_cmd.align = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_BIT: begin
				if (cnt_q == 5'd0) begin
					sh_cmd.commit   = 1'b1;
					fifo_ctl.commit = 1'b1;
					fifo_ctl.head   = head_w_q;
					fifo_ctl.fill   = fill_w_q;
				end else if (left_w != 4'd0) begin
					sh_cmd.shift = 1'b1;
				end
			end
			S_FETCH: begin
				if (rd_data != 8'hFF) begin
					sh_cmd.load      = 1'b1;
					sh_cmd.load_byte = rd_data;
				end
			end
			S_FF_CHK: begin
				if (rd_data != 8'h00) begin
					// marker: bytes stay consumed, bit buffer reloads with 0xff
					sh_cmd.marker   = 1'b1;
					fifo_ctl.commit = 1'b1;
				end else begin
					sh_cmd.load      = 1'b1;
					sh_cmd.load_byte = 8'hFF;
				end
			end
			S_RAW_HI: begin
				fifo_ctl.commit = !word_q;
			end
			S_RAW_LO: begin
				fifo_ctl.commit = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_PUSH;
			n_q          <= '0;
			cnt_q        <= '0;
			word_q       <= 1'b0;
			head_w_q     <= '0;
			fill_w_q     <= '0;
			res_value_q  <= '0;
			res_status_q <= ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp_ready)
				rsp_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q         <= req.opcode;
						n_q          <= req.bit_count;
						cnt_q        <= req.bit_count;
						word_q       <= (req.opcode == OP_READ_W);
						head_w_q     <= fifo_head;
						fill_w_q     <= fifo_fill;
						res_value_q  <= '0;
						res_status_q <= start_status;
						state_q      <= start_state;
					end
				end
				S_BIT: begin
					if (cnt_q == 5'd0) begin
						res_value_q <= bits_value;
						state_q     <= S_DONE;
					end else if (left_w == 4'd0) begin
						if (fill_w_q == FIFO_FILL_W'(0)) begin
							res_status_q <= ST_UNDERFLOW;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_FETCH;
						end
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				S_FETCH: begin
					head_w_q <= head_inc;
					fill_w_q <= fill_dec;
					if (rd_data == 8'hFF)
						state_q <= S_FF_WAIT;
					else
						state_q <= S_BIT;
				end
				S_FF_WAIT: begin
					// the stuffed byte must already be buffered
					if (fill_w_q == FIFO_FILL_W'(0)) begin
						res_status_q <= ST_UNDERFLOW;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_FF_CHK;
					end
				end
				S_FF_CHK: begin
					head_w_q <= head_inc;
					fill_w_q <= fill_dec;
					if (rd_data != 8'h00) begin
						res_status_q <= ST_MARKER;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_BIT;
					end
				end
				S_RAW_WAIT: begin
					state_q <= S_RAW_HI;
				end
				S_RAW_HI: begin
					res_value_q <= {8'h00, rd_data};
					head_w_q    <= head_inc;
					fill_w_q    <= fill_dec;
					state_q     <= word_q ? S_RAW_WAIT_LO : S_DONE;
				end
				S_RAW_WAIT_LO: begin
					state_q <= S_RAW_LO;
				end
				S_RAW_LO: begin
					res_value_q <= {res_value_q[7:0], rd_data};
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_q.value  <= res_value_q;
						rsp_q.status <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### hw/rtl/jbr_checker.sv
// ----------------------------------------------------------------------------
// jbr_checker
// Port-level checks for the bit reader, bound to the top level.
// ----------------------------------------------------------------------------
module jbr_checker import jbr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// a held result beat keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp beat changed while stalled");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// errors never carry data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.value == 16'h0000)
		else $error("error status with nonzero value");

	// status code in range
	a_status_rng: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= ST_FULL)
		else $error("status code out of range");

	// a push taken with the output empty answers ok or full
	a_push_status: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.opcode == OP_PUSH && !rsp_valid ##2 rsp_valid
		|-> rsp.status == ST_OK || rsp.status == ST_FULL)
		else $error("push answered with a read status");

endmodule

bind jpeg_bit_reader_unstuff jbr_checker u_jbr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the entropy bit reader with 0xFF 0x00 unstuffing.
// Each request beat is scored at acceptance by an in-bench copy of the reader
// (byte store, bit buffer, unstuffing, extend rule), and every response beat
// is checked in order against it. Both sides pace at random, and the run
// also covers a long response stall and a sender pause until drained.
// ----------------------------------------------------------------------------
module tb;
	import jbr_pkg::*;

	// opcodes the block leaves unused
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	localparam logic [7:0] MARKER_PREFIX = 8'hFF;
	localparam logic [7:0] STUFF_ZERO    = 8'h00;
	localparam logic [7:0] EOI_CODE      = 8'hD9;

	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD    = 300;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	jpeg_bit_reader_unstuff u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// reader state as the block should hold it
	logic [7:0]             fifo_mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  fifo_rd;
	logic [FIFO_FILL_W-1:0] fifo_cnt;
	logic [7:0]             bit_buf;
	logic [3:0]             bit_cnt;

	rsp_t answers_due [$];
	rsp_t want;
	int   mismatch_count;
	bit   pacing_on;
	int   rsp_hold_cycles;
	bit   stuff_pending;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("tb: mismatch at %0t ns: %s", $time, what);
	endtask

	function automatic logic [FIFO_PTR_W-1:0] next_slot(input logic [FIFO_PTR_W-1:0] p);
		return FIFO_PTR_W'((int'(p) + 1) % FIFO_DEPTH);
	endfunction

	function automatic logic [7:0] pop_byte();
		logic [7:0] b;
		b = fifo_mem[fifo_rd];
		fifo_rd = next_slot(fifo_rd);
		fifo_cnt--;
		return b;
	endfunction

	// msb-first bit read with unstuffing; state only moves on ok or marker
	function automatic logic [2:0] take_bits(input int n, output logic [15:0] bits);
		logic [7:0]             cur;
		logic [3:0]             left;
		logic [FIFO_PTR_W-1:0]  rd;
		logic [FIFO_FILL_W-1:0] cnt;
		logic [7:0]             b;
		logic [15:0]            acc;
		cur  = bit_buf;
		left = bit_cnt;
		rd   = fifo_rd;
		cnt  = fifo_cnt;
		acc  = '0;
		bits = '0;
		for (int i = 0; i < n; i++) begin
			if (left == 0) begin
				if (cnt == 0)
					return ST_UNDERFLOW;
				b = fifo_mem[rd];
				rd = next_slot(rd);
				cnt--;
				if (b == MARKER_PREFIX) begin
					if (cnt == 0)
						return ST_UNDERFLOW;
					cnt--;
					if (fifo_mem[rd] != STUFF_ZERO) begin
						// marker: both bytes gone, buffer refilled with 0xff
						fifo_rd  = next_slot(rd);
						fifo_cnt = cnt;
						bit_buf  = MARKER_PREFIX;
						bit_cnt  = 4'd8;
						return ST_MARKER;
					end
					rd = next_slot(rd);
				end
				cur  = b;
				left = 4'd8;
			end
			acc  = {acc[14:0], cur[7]};
			cur  = cur << 1;
			left = left - 4'd1;
		end
		bit_buf  = cur;
		bit_cnt  = left;
		fifo_rd  = rd;
		fifo_cnt = cnt;
		bits     = acc;
		return ST_OK;
	endfunction

	function automatic rsp_t reader_answer(input req_t item);
		rsp_t        res;
		logic [15:0] bits;
		int          n;
		res.value  = '0;
		res.status = ST_OK;
		n = int'(item.bit_count);
		case (item.opcode)
			OP_PUSH: begin
				if (fifo_cnt >= FIFO_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					fifo_mem[(int'(fifo_rd) + int'(fifo_cnt)) % FIFO_DEPTH] = item.stream_byte;
					fifo_cnt++;
				end
			end
			OP_READ_U: begin
				if (n > MAX_READ_BITS) begin
					res.status = ST_TOO_MANY;
				end else begin
					res.status = take_bits(n, bits);
					res.value  = bits;
				end
			end
			OP_READ_S: begin
				if (n > MAX_READ_BITS) begin
					res.status = ST_TOO_MANY;
				end else if (n > 0) begin
					res.status = take_bits(n, bits);
					if (res.status == ST_OK) begin
						// extend rule: clear top bit means negative
						if (!bits[n-1])
							bits = bits - 16'((32'd1 << n) - 1);
						res.value = bits;
					end
				end
			end
			OP_READ_B: begin
				if (bit_cnt != 0)
					res.status = ST_UNALIGNED;
				else if (fifo_cnt < 1)
					res.status = ST_UNDERFLOW;
				else
					res.value = {8'h00, pop_byte()};
			end
			OP_READ_W: begin
				if (bit_cnt != 0) begin
					res.status = ST_UNALIGNED;
				end else if (fifo_cnt < 2) begin
					res.status = ST_UNDERFLOW;
				end else begin
					res.value[15:8] = pop_byte();
					res.value[7:0]  = pop_byte();
				end
			end
			OP_ALIGN: begin
				bit_cnt = '0;
				bit_buf = '0;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic req_t make_req(input logic [2:0] op, input logic [7:0] b,
			input logic [4:0] n);
		req_t r;
		r.opcode      = op;
		r.stream_byte = b;
		r.bit_count   = n;
		return r;
	endfunction

	// mostly well-formed traffic that tends to keep the store neither empty nor full
	function automatic req_t random_req();
		req_t r;
		int   pick;
		int   push_weight;
		r = make_req(OP_PUSH, 8'($urandom), 5'($urandom_range(0, 16)));
		if ($urandom_range(0, 99) < 12) begin
			r.opcode    = 3'($urandom_range(0, 7));
			r.bit_count = 5'($urandom_range(0, 31));
			if (r.opcode == OP_PUSH)
				stuff_pending = 1'b0;
			return r;
		end
		if (stuff_pending && fifo_cnt < FIFO_DEPTH) begin
			stuff_pending = 1'b0;
			if ($urandom_range(0, 9) != 0)
				r.stream_byte = STUFF_ZERO;
			else
				r.stream_byte = 8'($urandom_range(1, 255));
			return r;
		end
		push_weight = (fifo_cnt < 3) ? 70 : (fifo_cnt >= FIFO_DEPTH - 1) ? 15 : 40;
		if ($urandom_range(0, 99) < push_weight) begin
			if ($urandom_range(0, 99) < 15) begin
				r.stream_byte = MARKER_PREFIX;
				stuff_pending = 1'b1;
			end
			return r;
		end
		if ($urandom_range(0, 9) < 7)
			r.bit_count = 5'($urandom_range(1, 8));
		pick = $urandom_range(0, 99);
		if (pick < 40)
			r.opcode = OP_READ_U;
		else if (pick < 70)
			r.opcode = OP_READ_S;
		else if (pick < 80)
			r.opcode = (bit_cnt == 0) ? OP_READ_B : OP_ALIGN;
		else if (pick < 88)
			r.opcode = (bit_cnt == 0) ? OP_READ_W : OP_ALIGN;
		else if (pick < 96)
			r.opcode = OP_ALIGN;
		else
			r.opcode = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
		return r;
	endfunction

	task automatic send_beat(input req_t item);
		int gap;
		gap = pacing_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		answers_due.push_back(reader_answer(item));
	endtask

	task automatic pause_until_drained();
		req_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_corner_cases();
		// empty store: zero-bit reads, underflows, rejected widths, spare opcodes
		send_beat(make_req(OP_READ_U, 8'h00, 5'd0));
		send_beat(make_req(OP_READ_U, 8'h00, 5'd1));
		send_beat(make_req(OP_READ_S, 8'h00, 5'd0));
		send_beat(make_req(OP_READ_B, 8'h00, 5'd0));
		send_beat(make_req(OP_READ_W, 8'h00, 5'd0));
		send_beat(make_req(OP_READ_U, 8'h00, 5'd31));
		send_beat(make_req(OP_READ_S, 8'h00, 5'd17));
		send_beat(make_req(OP_SPARE_6, 8'hFF, 5'd31));
		send_beat(make_req(OP_SPARE_7, 8'h00, 5'd0));
		// fill the store, then one push too many
		send_beat(make_req(OP_PUSH, MARKER_PREFIX, 5'd0));
		send_beat(make_req(OP_PUSH, STUFF_ZERO, 5'd0));
		send_beat(make_req(OP_PUSH, 8'h80, 5'd0));
		send_beat(make_req(OP_PUSH, MARKER_PREFIX, 5'd0));
		send_beat(make_req(OP_PUSH, EOI_CODE, 5'd0));
		send_beat(make_req(OP_PUSH, STUFF_ZERO, 5'd0));
		send_beat(make_req(OP_PUSH, MARKER_PREFIX, 5'd0));
		send_beat(make_req(OP_PUSH, STUFF_ZERO, 5'd0));
		send_beat(make_req(OP_PUSH, 8'h55, 5'd0));
		// stuffed byte across a 16-bit signed read, then a marker
		send_beat(make_req(OP_READ_S, 8'h00, 5'd16));
		send_beat(make_req(OP_READ_U, 8'h00, 5'd1));
		send_beat(make_req(OP_READ_B, 8'h00, 5'd0));
		send_beat(make_req(OP_READ_S, 8'h00, 5'd5));
		send_beat(make_req(OP_ALIGN, 8'h00, 5'd0));
		// raw reads do not unstuff
		send_beat(make_req(OP_READ_B, 8'h00, 5'd0));
		send_beat(make_req(OP_READ_W, 8'h00, 5'd0));
		send_beat(make_req(OP_PUSH, 8'h01, 5'd0));
		send_beat(make_req(OP_READ_S, 8'h00, 5'd8));
		pause_until_drained();
	endtask

	task automatic test_rsp_backpressure();
		pacing_on = 1'b0;
		rsp_hold_cycles = LONG_HOLD;
		repeat (24)
			send_beat(random_req());
		pause_until_drained();
		pacing_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		repeat (12)
			send_beat(random_req());
		pause_until_drained();
		repeat (12)
			send_beat(random_req());
	endtask

	task automatic test_random_stream(input int n_items);
		for (int k = 0; k < n_items; k++) begin
			// a stretch without pacing on either side now and then
			if (k % 200 == 100)
				pacing_on = 1'b0;
			if (k % 200 == 150)
				pacing_on = 1'b1;
			send_beat(random_req());
		end
		pacing_on = 1'b1;
	endtask

	// response pacing: a fresh stall is drawn after every beat
	initial begin : rsp_pacer
		int stall;
		stall = 0;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_hold_cycles > 0) begin
				stall = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else if (rsp_valid && rsp_ready) begin
				stall = pacing_on ? $urandom_range(0, 8) : 0;
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				stall--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (answers_due.size() == 0) begin
				report_mismatch("response beat with nothing outstanding");
			end else begin
				want = answers_due.pop_front();
				if (rsp.value !== want.value)
					report_mismatch($sformatf("value got %h want %h", rsp.value, want.value));
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						rsp.status, want.status));
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		req             = '0;
		fifo_rd         = '0;
		fifo_cnt        = '0;
		bit_buf         = '0;
		bit_cnt         = '0;
		mismatch_count  = 0;
		pacing_on       = 1'b1;
		rsp_hold_cycles = 0;
		stuff_pending   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_corner_cases();
		test_rsp_backpressure();
		test_sender_pause();
		test_random_stream(1080);

		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
